[design/touch_report_gesture_classifier_macros.svh]
// assertion macros for the checker file
// no dependencies
`ifndef TOUCH_REPORT_GESTURE_CLASSIFIER_MACROS_SVH
`define TOUCH_REPORT_GESTURE_CLASSIFIER_MACROS_SVH

// clocked property, switched off while reset is high
`define TRGC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds across reset
`define TRGC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/trgc_pkg.sv]
// types, codes and helpers for the touch report gesture classifier
// no dependencies
`timescale 1ns / 1ps

package trgc_pkg;

  localparam int COORD_BITS     = 12;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = COORD_BITS + 1;
  localparam int KIND_BITS      = 3;
  localparam int HOLD_BITS      = 8;

  localparam logic [CFG_DATA_BITS-1:0] EXTENT_MAX = CFG_DATA_BITS'(1 << COORD_BITS);

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SWIPE_X_THRESHOLD = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SWIPE_Y_THRESHOLD = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_MARGIN       = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_TICKS        = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIRROR_X          = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIRROR_Y          = 3'd7;

  // event codes
  localparam logic [KIND_BITS-1:0] EV_UP     = 3'd0;
  localparam logic [KIND_BITS-1:0] EV_DOWN   = 3'd1;
  localparam logic [KIND_BITS-1:0] EV_HOLD   = 3'd2;
  localparam logic [KIND_BITS-1:0] EV_MOVE   = 3'd3;
  localparam logic [KIND_BITS-1:0] EV_RIGHT  = 3'd4;
  localparam logic [KIND_BITS-1:0] EV_LEFT   = 3'd5;
  localparam logic [KIND_BITS-1:0] EV_DSWIPE = 3'd6;
  localparam logic [KIND_BITS-1:0] EV_USWIPE = 3'd7;

  // reset values; limits hold extent minus one
  localparam logic [COORD_BITS-1:0] RST_LIMIT     = 12'd239;
  localparam logic [COORD_BITS-1:0] RST_SWIPE_THR = 12'd120;
  localparam logic [COORD_BITS-1:0] RST_MARGIN    = 12'd25;
  localparam logic [HOLD_BITS-1:0]  RST_HOLD      = 8'd30;

  // report flag bit positions
  localparam int FLAG_MORE  = 3;
  localparam int FLAG_THREE = 2;

  typedef struct packed {
    logic [7:0] ready_status;
    logic       read_ok;
    logic [7:0] report_flags;
    logic [7:0] report_extra;
    logic [7:0] first_x_low;
    logic [7:0] first_high_nibbles;
    logic [7:0] first_y_low;
    logic [7:0] second_x_low;
    logic [7:0] second_high_nibbles;
    logic [7:0] second_y_low;
  } report_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]  event_kind;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  last_of_run;
  } event_t;

  // extent register value to largest legal coordinate
  function automatic logic [COORD_BITS-1:0] to_limit(input logic [CFG_DATA_BITS-1:0] v);
    logic [CFG_DATA_BITS-1:0] m1;
    m1 = v - CFG_DATA_BITS'(1);
    if (v == '0) begin
      return '0;
    end else if (v > EXTENT_MAX) begin
      return '1;
    end
    return m1[COORD_BITS-1:0];
  endfunction

endpackage

[design/touch_report_gesture_classifier.sv]
// touch report gesture classifier top level
// depends on trgc_pkg
`timescale 1ns / 1ps

// Takes one raw two-finger touch report per input transaction and gives up to two
// gesture events (finger 0 first), the final one marked by last_of_run. The held
// report is walked one finger per cycle, while the pending and output stages do
// not stall, through a single shared gesture tracker; a new report is accepted
// when none is held or when the second finger of the held one steps. An event
// waits one stage until it is known whether another follows from the same
// report, then sits in the output register. Reports that are dropped give no
// transaction at all. Configuration takes effect as soon as it is written, also
// on a held report; no clearing pass follows reset.
module touch_report_gesture_classifier (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  trgc_pkg::report_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output trgc_pkg::event_t                     out_data,
  input  logic                                 cfg_write,
  input  logic [trgc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [trgc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int CB = trgc_pkg::COORD_BITS;

  // configuration
  logic [CB-1:0]                  lim_x, lim_y, thr_x, thr_y, margin;
  logic [trgc_pkg::HOLD_BITS-1:0] hold_ticks;
  logic                           mirror_x, mirror_y;

  // held report
  logic              iv, phase;
  trgc_pkg::report_t item;

  // tracker state
  logic [trgc_pkg::KIND_BITS-1:0] gstate, gstate_next;
  logic [trgc_pkg::HOLD_BITS-1:0] hold_count, hold_count_next, hold_inc;
  logic [CB-1:0]                  anchor_x, anchor_y, anchor_x_next, anchor_y_next;
  logic                           swipe_done, swipe_done_next;
  logic [1:0]                     active;
  logic [CB-1:0]                  raw_x [2];
  logic [CB-1:0]                  raw_y [2];

  // pending and output stages
  logic             pv, pfinal, ov;
  trgc_pkg::event_t pres, ores, push_res;

  logic          drop, present, do_press, do_lift, emit, p_emit;
  logic          step_go, out_free, pend_push, accept;
  logic [CB-1:0] fx_raw, fy_raw, src_x, src_y, cx, cy, px, py;
  logic [CB-1:0] dx, dy, ddiff;
  logic          on_anchor, swipe;

  assign out_free  = !ov || !out_stall;
  assign step_go   = iv && (!pv || out_free);
  assign in_stall  = iv && !(step_go && phase);
  assign accept    = in_valid && !in_stall;
  assign out_valid = ov;
  assign out_data  = ores;

  assign drop = !(item.ready_status[7] || item.ready_status[0]) || !item.read_ok ||
                (|item.report_flags[7:4]) || item.report_extra[0];

  assign fx_raw  = phase ? {item.second_high_nibbles[3:0], item.second_x_low}
                         : {item.first_high_nibbles[3:0], item.first_x_low};
  assign fy_raw  = phase ? {item.second_high_nibbles[7:4], item.second_y_low}
                         : {item.first_high_nibbles[7:4], item.first_y_low};
  assign present = phase ? item.report_flags[1] : item.report_flags[0];

  assign do_press = !drop && item.report_flags[trgc_pkg::FLAG_MORE] &&
                    !item.report_flags[trgc_pkg::FLAG_THREE] && present;
  assign do_lift  = !drop && active[phase] &&
                    (!item.report_flags[trgc_pkg::FLAG_MORE] ||
                     (!item.report_flags[trgc_pkg::FLAG_THREE] && !present));

  // clamp and mirror
  assign src_x = do_press ? fx_raw : raw_x[phase];
  assign src_y = do_press ? fy_raw : raw_y[phase];
  assign cx    = (src_x > lim_x) ? lim_x : src_x;
  assign cy    = (src_y > lim_y) ? lim_y : src_y;
  assign px    = mirror_x ? lim_x - cx : cx;
  assign py    = mirror_y ? lim_y - cy : cy;

  assign dx        = (px > anchor_x) ? px - anchor_x : anchor_x - px;
  assign dy        = (py > anchor_y) ? py - anchor_y : anchor_y - py;
  assign ddiff     = (dx > dy) ? dx - dy : dy - dx;
  assign on_anchor = (px == anchor_x) && (py == anchor_y);
  assign swipe     = !swipe_done && ((dx >= thr_x) || (dy >= thr_y)) && (ddiff >= margin);
  assign hold_inc  = hold_count + 8'd1;

  always_comb begin
    gstate_next     = gstate;
    hold_count_next = hold_count;
    anchor_x_next   = anchor_x;
    anchor_y_next   = anchor_y;
    swipe_done_next = swipe_done;
    p_emit          = 1'b0;
    if (do_lift) begin
      gstate_next     = trgc_pkg::EV_UP;
      hold_count_next = '0;
    end else if (do_press) begin
      if (gstate == trgc_pkg::EV_DOWN && on_anchor) begin
        if (hold_inc < hold_ticks) begin
          hold_count_next = hold_inc;
        end else begin
          gstate_next     = trgc_pkg::EV_HOLD;
          hold_count_next = '0;
          p_emit          = 1'b1;
        end
      end else if (gstate != trgc_pkg::EV_UP) begin
        if (swipe) begin
          if (dx > dy) begin
            gstate_next = (px > anchor_x) ? trgc_pkg::EV_RIGHT : trgc_pkg::EV_LEFT;
          end else begin
            gstate_next = (py > anchor_y) ? trgc_pkg::EV_DSWIPE : trgc_pkg::EV_USWIPE;
          end
          swipe_done_next = 1'b1;
          p_emit          = 1'b1;
        end else if (!((px == anchor_x) || (py == anchor_y))) begin
          gstate_next = trgc_pkg::EV_MOVE;
          p_emit      = 1'b1;
        end
      end else begin
        gstate_next     = trgc_pkg::EV_DOWN;
        anchor_x_next   = px;
        anchor_y_next   = py;
        swipe_done_next = 1'b0;
        p_emit          = 1'b1;
      end
    end
  end

  assign emit      = do_lift || (do_press && p_emit);
  assign pend_push = pv && out_free && (pfinal || (step_go && emit));

  always_comb begin
    push_res             = pres;
    push_res.last_of_run = pfinal;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_x      <= trgc_pkg::RST_LIMIT;
      lim_y      <= trgc_pkg::RST_LIMIT;
      thr_x      <= trgc_pkg::RST_SWIPE_THR;
      thr_y      <= trgc_pkg::RST_SWIPE_THR;
      margin     <= trgc_pkg::RST_MARGIN;
      hold_ticks <= trgc_pkg::RST_HOLD;
      mirror_x   <= 1'b1;
      mirror_y   <= 1'b1;
      iv         <= 1'b0;
      phase      <= 1'b0;
      gstate     <= trgc_pkg::EV_UP;
      hold_count <= '0;
      anchor_x   <= '0;
      anchor_y   <= '0;
      swipe_done <= 1'b0;
      active     <= '0;
      pv         <= 1'b0;
      pfinal     <= 1'b0;
      ov         <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          trgc_pkg::REG_SCREEN_WIDTH:      lim_x      <= trgc_pkg::to_limit(cfg_data);
          trgc_pkg::REG_SCREEN_HEIGHT:     lim_y      <= trgc_pkg::to_limit(cfg_data);
          trgc_pkg::REG_SWIPE_X_THRESHOLD: thr_x      <= cfg_data[CB-1:0];
          trgc_pkg::REG_SWIPE_Y_THRESHOLD: thr_y      <= cfg_data[CB-1:0];
          trgc_pkg::REG_AXIS_MARGIN:       margin     <= cfg_data[CB-1:0];
          trgc_pkg::REG_HOLD_TICKS:        hold_ticks <= cfg_data[trgc_pkg::HOLD_BITS-1:0];
          trgc_pkg::REG_MIRROR_X:          mirror_x   <= cfg_data[0];
          trgc_pkg::REG_MIRROR_Y:          mirror_y   <= cfg_data[0];
          default: begin
          end
        endcase
      end

      // one finger per step
      if (!iv || (step_go && phase)) begin
        iv <= accept;
      end
      if (step_go) begin
        phase      <= !phase;
        gstate     <= gstate_next;
        hold_count <= hold_count_next;
        anchor_x   <= anchor_x_next;
        anchor_y   <= anchor_y_next;
        swipe_done <= swipe_done_next;
        if (do_press) begin
          active[phase] <= 1'b1;
        end else if (do_lift) begin
          active[phase] <= 1'b0;
        end
      end

      // pending event waits until its last flag is known
      if (step_go && emit) begin
        pv     <= 1'b1;
        pfinal <= phase;
      end else if (pend_push) begin
        pv <= 1'b0;
      end else if (step_go && phase && pv) begin
        pfinal <= 1'b1;
      end

      if (pend_push) begin
        ov <= 1'b1;
      end else if (!out_stall) begin
        ov <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    if (step_go && do_press) begin
      raw_x[phase] <= fx_raw;
      raw_y[phase] <= fy_raw;
    end
    if (step_go && emit) begin
      pres.event_kind  <= gstate_next;
      pres.pos_x       <= px;
      pres.pos_y       <= py;
      pres.last_of_run <= 1'b0;
    end
    if (pend_push) begin
      ores <= push_res;
    end
  end

endmodule

[design/trgc_checker.sv]
// port-level checks for the touch report gesture classifier, bound to the top level
// depends on trgc_pkg and touch_report_gesture_classifier_macros.svh
`timescale 1ns / 1ps
`include "touch_report_gesture_classifier_macros.svh"

module trgc_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input trgc_pkg::event_t out_data
);

  // a stalled result holds
  `TRGC_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

  // reset leaves no result and an open input
  `TRGC_ASSERT_NR(a_reset_clear, clk, rst |=> !out_valid && !in_stall, "reset did not clear the pipeline")

  // with a free output the input stall ends when the held report's second finger steps
  `TRGC_ASSERT(a_rate, clk, rst, in_stall && !out_stall ##1 !out_stall |-> !in_stall, "input stalled beyond the second finger step")

endmodule

bind touch_report_gesture_classifier trgc_checker u_trgc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[dv/touch_report_gesture_classifier_test.sv]
// self-checking testbench for touch_report_gesture_classifier: directed and random
// touch reports, random idling on both channels, events checked against a local tracker
// depends on trgc_pkg and the touch_report_gesture_classifier rtl
`timescale 1ns / 1ps

module touch_report_gesture_classifier_test;

  localparam int DRAIN_CYCLES = 10;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_TOUCHES = 225;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  trgc_pkg::report_t in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  trgc_pkg::event_t  out_data;
  logic              cfg_write = 1'b0;
  logic [trgc_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [trgc_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  // register copies
  logic [12:0] cur_w = 13'd240;
  logic [12:0] cur_h = 13'd240;
  logic [11:0] cur_tx = 12'd120;
  logic [11:0] cur_ty = 12'd120;
  logic [11:0] cur_margin = 12'd25;
  logic [7:0]  cur_hold = 8'd30;
  logic        cur_mx = 1'b1;
  logic        cur_my = 1'b1;

  // gesture tracker and finger copies
  logic [trgc_pkg::KIND_BITS-1:0] trk_state = trgc_pkg::EV_UP;
  logic [7:0]  trk_hold = '0;
  logic [11:0] trk_ax = '0;
  logic [11:0] trk_ay = '0;
  logic        trk_swiped = 1'b0;
  logic [1:0]  fng_on = '0;
  logic [11:0] fng_x [2] = '{default: '0};
  logic [11:0] fng_y [2] = '{default: '0};

  trgc_pkg::event_t run_events [$];
  trgc_pkg::event_t pending_events [$];
  int     mismatch_count = 0;
  int     touches_sent = 0;
  bit     feed_gaps = 1'b1;
  bit     sink_gaps = 1'b1;
  bit     hold_request = 1'b0;

  touch_report_gesture_classifier u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- tracker

  function automatic logic [11:0] extent_top(input logic [12:0] v);
    if (v == 13'd0) return 12'd0;
    if (v > 13'd4096) return 12'hFFF;
    return 12'(v - 13'd1);
  endfunction

  function automatic logic [11:0] span(input logic [11:0] a, input logic [11:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void map_point(input logic [11:0] rx, input logic [11:0] ry,
                                    output logic [11:0] px, output logic [11:0] py);
    logic [11:0] xt, yt;
    xt = extent_top(cur_w);
    yt = extent_top(cur_h);
    px = (rx > xt) ? xt : rx;
    py = (ry > yt) ? yt : ry;
    if (cur_mx) px = xt - px;
    if (cur_my) py = yt - py;
  endfunction

  function automatic void record(input logic [trgc_pkg::KIND_BITS-1:0] kind,
                                 input logic [11:0] x, input logic [11:0] y);
    trgc_pkg::event_t ev;
    ev.event_kind  = kind;
    ev.pos_x       = x;
    ev.pos_y       = y;
    ev.last_of_run = 1'b0;
    run_events.push_back(ev);
  endfunction

  function automatic void track_press(input logic [11:0] rx, input logic [11:0] ry);
    logic [11:0] x, y, dx, dy;
    map_point(rx, ry, x, y);
    if (trk_state == trgc_pkg::EV_DOWN && x == trk_ax && y == trk_ay) begin
      trk_hold = trk_hold + 8'd1;
      if (trk_hold < cur_hold) return;
      trk_state = trgc_pkg::EV_HOLD;
      trk_hold = '0;
      record(trgc_pkg::EV_HOLD, x, y);
      return;
    end
    if (trk_state != trgc_pkg::EV_UP) begin
      dx = span(x, trk_ax);
      dy = span(y, trk_ay);
      if (!trk_swiped && (dx >= cur_tx || dy >= cur_ty) && span(dx, dy) >= cur_margin) begin
        if (dx > dy) begin
          trk_state = (x > trk_ax) ? trgc_pkg::EV_RIGHT : trgc_pkg::EV_LEFT;
        end else begin
          trk_state = (y > trk_ay) ? trgc_pkg::EV_DSWIPE : trgc_pkg::EV_USWIPE;
        end
        trk_swiped = 1'b1;
      end else begin
        if (x == trk_ax || y == trk_ay) return;
        trk_state = trgc_pkg::EV_MOVE;
      end
    end else begin
      trk_state = trgc_pkg::EV_DOWN;
      trk_ax = x;
      trk_ay = y;
      trk_swiped = 1'b0;
    end
    record(trk_state, x, y);
  endfunction

  function automatic void track_lift(input int f);
    logic [11:0] x, y;
    map_point(fng_x[f], fng_y[f], x, y);
    trk_state = trgc_pkg::EV_UP;
    trk_hold = '0;
    record(trgc_pkg::EV_UP, x, y);
  endfunction

  // events caused by one accepted report, queued in order
  function automatic void classify_report(input trgc_pkg::report_t r);
    logic [7:0] hi;
    run_events.delete();
    if ((r.ready_status[7] || r.ready_status[0]) && r.read_ok && r.report_flags[7:4] == 4'd0
        && !r.report_extra[0]) begin
      if (!r.report_flags[trgc_pkg::FLAG_MORE]) begin
        for (int f = 0; f < 2; f++) begin
          if (fng_on[f]) begin
            fng_on[f] = 1'b0;
            track_lift(f);
          end
        end
      end else if (!r.report_flags[trgc_pkg::FLAG_THREE]) begin
        for (int f = 0; f < 2; f++) begin
          if (r.report_flags[f]) begin
            hi = (f == 0) ? r.first_high_nibbles : r.second_high_nibbles;
            fng_x[f] = {hi[3:0], (f == 0) ? r.first_x_low : r.second_x_low};
            fng_y[f] = {hi[7:4], (f == 0) ? r.first_y_low : r.second_y_low};
            fng_on[f] = 1'b1;
            track_press(fng_x[f], fng_y[f]);
          end else if (fng_on[f]) begin
            track_lift(f);
            fng_on[f] = 1'b0;
          end
        end
      end
    end
    if (run_events.size() > 0) run_events[$].last_of_run = 1'b1;
    foreach (run_events[i]) pending_events.push_back(run_events[i]);
  endfunction

  // ---------------------------------------------------------------- reports

  function automatic trgc_pkg::report_t make_touch(input logic [1:0] fingers,
                                                   input logic [11:0] x0,
                                                   input logic [11:0] y0,
                                                   input logic [11:0] x1,
                                                   input logic [11:0] y1);
    trgc_pkg::report_t r;
    r.ready_status = 8'($urandom);
    if (!r.ready_status[7] && !r.ready_status[0]) r.ready_status[0] = 1'b1;
    r.read_ok = 1'b1;
    r.report_flags = {4'd0, 1'b1, 1'b0, fingers};
    r.report_extra = 8'($urandom) & 8'hFE;
    r.first_x_low = x0[7:0];
    r.first_y_low = y0[7:0];
    r.first_high_nibbles = {y0[11:8], x0[11:8]};
    r.second_x_low = x1[7:0];
    r.second_y_low = y1[7:0];
    r.second_high_nibbles = {y1[11:8], x1[11:8]};
    return r;
  endfunction

  // end of data: lifts every active finger
  function automatic trgc_pkg::report_t make_release();
    trgc_pkg::report_t r;
    r = make_touch(2'($urandom), 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
    r.report_flags = {4'd0, 1'b0, 3'($urandom)};
    return r;
  endfunction

  function automatic trgc_pkg::report_t noise_report();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return trgc_pkg::report_t'(bits[$bits(trgc_pkg::report_t)-1:0]);
  endfunction

  function automatic trgc_pkg::report_t spoil_report(input trgc_pkg::report_t r);
    case ($urandom_range(0, 4))
      0: r.ready_status = r.ready_status & 8'h7E;
      1: r.read_ok = 1'b0;
      2: r.report_flags[7:4] = 4'($urandom_range(1, 15));
      3: r.report_extra[0] = 1'b1;
      default: r.report_flags[trgc_pkg::FLAG_THREE] = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] pick_coord(input logic [12:0] ext);
    int top;
    top = int'(extent_top(ext));
    if ($urandom_range(0, 7) == 0) return 12'($urandom);
    top = top + top / 8 + 2;
    if (top > 4095) top = 4095;
    return 12'($urandom_range(0, top));
  endfunction

  function automatic logic [1:0] pick_fingers();
    int p;
    p = $urandom_range(0, 9);
    if (p < 7) return 2'b01;
    if (p < 9) return 2'b11;
    return 2'b10;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_report(input trgc_pkg::report_t r);
    int gap;
    gap = feed_gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    classify_report(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [trgc_pkg::CFG_INDEX_BITS-1:0] idx,
                         input logic [trgc_pkg::CFG_DATA_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      trgc_pkg::REG_SCREEN_WIDTH:      cur_w = val;
      trgc_pkg::REG_SCREEN_HEIGHT:     cur_h = val;
      trgc_pkg::REG_SWIPE_X_THRESHOLD: cur_tx = val[11:0];
      trgc_pkg::REG_SWIPE_Y_THRESHOLD: cur_ty = val[11:0];
      trgc_pkg::REG_AXIS_MARGIN:       cur_margin = val[11:0];
      trgc_pkg::REG_HOLD_TICKS:        cur_hold = val[7:0];
      trgc_pkg::REG_MIRROR_X:          cur_mx = val[0];
      trgc_pkg::REG_MIRROR_Y:          cur_my = val[0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [12:0] w, input logic [12:0] h,
                             input logic [11:0] tx, input logic [11:0] ty,
                             input logic [11:0] margin, input logic [7:0] hold,
                             input logic mx, input logic my);
    wait_drained();
    put_reg(trgc_pkg::REG_SCREEN_WIDTH, w);
    put_reg(trgc_pkg::REG_SCREEN_HEIGHT, h);
    put_reg(trgc_pkg::REG_SWIPE_X_THRESHOLD, 13'(tx));
    put_reg(trgc_pkg::REG_SWIPE_Y_THRESHOLD, 13'(ty));
    put_reg(trgc_pkg::REG_AXIS_MARGIN, 13'(margin));
    put_reg(trgc_pkg::REG_HOLD_TICKS, 13'(hold));
    put_reg(trgc_pkg::REG_MIRROR_X, 13'(mx));
    put_reg(trgc_pkg::REG_MIRROR_Y, 13'(my));
    cfg_write <= 1'b0;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] %s", $time, what);
  endtask

  initial begin : event_checker
    trgc_pkg::event_t want;
    int               n;
    forever begin
      @(posedge clk);
      n = 0;
      if (!rst && out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event kind %0d at (%0d,%0d)",
                                    out_data.event_kind, out_data.pos_x, out_data.pos_y));
        end else begin
          want = pending_events.pop_front();
          if (out_data.event_kind !== want.event_kind)
            report_mismatch($sformatf("event_kind got %0d want %0d",
                                      out_data.event_kind, want.event_kind));
          if (out_data.pos_x !== want.pos_x)
            report_mismatch($sformatf("pos_x got %0d want %0d", out_data.pos_x, want.pos_x));
          if (out_data.pos_y !== want.pos_y)
            report_mismatch($sformatf("pos_y got %0d want %0d", out_data.pos_y, want.pos_y));
          if (out_data.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run got %0b want %0b",
                                      out_data.last_of_run, want.last_of_run));
        end
        n = sink_gaps ? $urandom_range(0, 16) : 0;
      end
      if (hold_request) begin
        hold_request = 1'b0;
        n = LONG_HOLD;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  task automatic test_drop_rules();
    trgc_pkg::report_t r;
    r = make_touch(2'b01, 12'd10, 12'd20, 12'd0, 12'd0);
    r.ready_status = 8'h7E;
    send_report(r);
    r = make_touch(2'b11, 12'd10, 12'd20, 12'd30, 12'd40);
    r.read_ok = 1'b0;
    send_report(r);
    r = make_touch(2'b01, 12'd10, 12'd20, 12'd0, 12'd0);
    r.report_flags[7:4] = 4'hF;
    r.report_extra = 8'hFF;
    send_report(r);
    r = make_touch(2'b01, 12'd10, 12'd20, 12'd0, 12'd0);
    r.report_extra = 8'hFF;
    send_report(r);
    r = make_touch(2'b11, 12'd10, 12'd20, 12'd30, 12'd40);
    r.report_flags[trgc_pkg::FLAG_THREE] = 1'b1;
    send_report(r);
    send_report(make_release());
  endtask

  task automatic test_tracker();
    trgc_pkg::report_t r;
    r = make_touch(2'b01, 12'd0, 12'd0, 12'd0, 12'd0);
    r.ready_status = 8'h01;
    send_report(r);
    send_report(make_touch(2'b01, 12'd0, 12'd0, 12'd0, 12'd0));
    // same x as the anchor gives no event
    send_report(make_touch(2'b01, 12'd0, 12'd5, 12'd0, 12'd0));
    send_report(make_touch(2'b01, 12'd10, 12'd5, 12'd0, 12'd0));
    send_report(make_touch(2'b01, 12'd200, 12'd10, 12'd0, 12'd0));
    // swipe already taken in this touch
    send_report(make_touch(2'b01, 12'd5, 12'd239, 12'd0, 12'd0));
    send_report(make_touch(2'b00, 12'd0, 12'd0, 12'd0, 12'd0));
    r = make_touch(2'b01, 12'hFFF, 12'hFFF, 12'd0, 12'd0);
    r.ready_status = 8'h80;
    send_report(r);
    send_report(make_release());
  endtask

  task automatic test_two_fingers();
    send_report(make_touch(2'b11, 12'd100, 12'd100, 12'hFFF, 12'd0));
    send_report(make_touch(2'b10, 12'd0, 12'd0, 12'hFFF, 12'hFFF));
    send_report(make_release());
  endtask

  task automatic test_lift_after_config();
    send_report(make_touch(2'b01, 12'd30, 12'd40, 12'd0, 12'd0));
    load_config(13'd240, 13'd240, 12'd120, 12'd120, 12'd25, 8'd30, 1'b0, 1'b0);
    send_report(make_release());
  endtask

  task automatic test_extents();
    load_config(13'd0, 13'd8191, 12'd0, 12'd0, 12'd0, 8'd0, 1'b0, 1'b1);
    send_report(make_touch(2'b01, 12'hFFF, 12'h000, 12'd0, 12'd0));
    send_report(make_touch(2'b01, 12'hFFF, 12'h000, 12'd0, 12'd0));
    send_report(make_touch(2'b01, 12'hABC, 12'h123, 12'd0, 12'd0));
    send_report(make_release());
    load_config(13'd4096, 13'd4097, 12'd4095, 12'd4095, 12'd4095, 8'd255, 1'b1, 1'b0);
    send_report(make_touch(2'b11, 12'hFFF, 12'hFFF, 12'h000, 12'h000));
    send_report(make_release());
  endtask

  task automatic test_backpressure();
    wait_drained();
    feed_gaps = 1'b0;
    sink_gaps = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 24; i++) begin
      if (i % 2 == 0) send_report(make_touch(2'b01, 12'(i * 97), 12'(i * 53), 12'd0, 12'd0));
      else send_report(make_release());
    end
    wait_drained();
  endtask

  task automatic random_touch_session();
    logic [11:0] x0, y0, x1, y1;
    logic [1:0]  fingers;
    int          steps, pick;
    x0 = pick_coord(cur_w);
    y0 = pick_coord(cur_h);
    x1 = pick_coord(cur_w);
    y1 = pick_coord(cur_h);
    fingers = pick_fingers();
    steps = $urandom_range(1, 10);
    repeat (steps) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_report(noise_report());
      end else if (pick < 16) begin
        send_report(spoil_report(make_touch(fingers, x0, y0, x1, y1)));
      end else begin
        if (pick >= 40 && pick < 65) begin
          x0 = x0 + 12'($urandom_range(0, 12)) - 12'd6;
          y0 = y0 + 12'($urandom_range(0, 12)) - 12'd6;
          x1 = x1 + 12'($urandom_range(0, 12)) - 12'd6;
          y1 = y1 + 12'($urandom_range(0, 12)) - 12'd6;
        end else if (pick >= 65 && pick < 78) begin
          x0 = pick_coord(cur_w);
          y0 = pick_coord(cur_h);
        end else if (pick >= 78 && pick < 88) begin
          x0 = x0 + 12'($urandom_range(1, 9));
        end else if (pick >= 88) begin
          fingers = pick_fingers();
        end
        send_report(make_touch(fingers, x0, y0, x1, y1));
        touches_sent++;
      end
    end
    if ($urandom_range(0, 1) == 0) send_report(make_release());
    else send_report(make_touch(2'b00, x0, y0, x1, y1));
    touches_sent++;
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          load_config(13'd240, 13'd320, 12'd40, 12'd40, 12'd10, 8'd3, 1'b0, 1'b0);
          feed_gaps = 1'b1;
          sink_gaps = 1'b1;
        end
        1: begin
          load_config(13'd4096, 13'd4096, 12'd0, 12'd0, 12'd0, 8'd1, 1'b1, 1'b1);
          feed_gaps = 1'b0;
          sink_gaps = 1'b0;
        end
        2: begin
          load_config(13'd1, 13'd8191, 12'd4095, 12'd4095, 12'd4095, 8'd255, 1'b1, 1'b0);
          feed_gaps = 1'b1;
          sink_gaps = 1'b0;
        end
        3: begin
          load_config(13'($urandom_range(16, 600)), 13'($urandom_range(16, 600)),
                      12'($urandom_range(0, 200)), 12'($urandom_range(0, 200)),
                      12'($urandom_range(0, 60)), 8'($urandom_range(1, 5)),
                      1'($urandom), 1'($urandom));
          feed_gaps = 1'b0;
          sink_gaps = 1'b1;
        end
        4: begin
          load_config(13'd0, 13'd0, 12'd20, 12'd20, 12'd5, 8'd0, 1'b0, 1'b1);
          feed_gaps = 1'b1;
          sink_gaps = 1'b1;
        end
        default: begin
          load_config(13'($urandom), 13'($urandom), 12'($urandom_range(0, 300)),
                      12'($urandom_range(0, 300)), 12'($urandom_range(0, 100)),
                      8'($urandom_range(0, 6)), 1'($urandom), 1'($urandom));
          feed_gaps = 1'b1;
          sink_gaps = 1'b1;
        end
      endcase
      touches_sent = 0;
      while (touches_sent < PHASE_TOUCHES) random_touch_session();
    end
  endtask

  initial begin : run
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_drop_rules();
    test_tracker();
    test_two_fingers();
    test_lift_after_config();
    test_extents();
    test_backpressure();
    test_random();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
